FILE: design/mef_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mef_pkg
// Shared types and constants of the majority element finder.
// ----------------------------------------------------------------------------
package mef_pkg;

	localparam int VALUE_W     = 32;
	localparam int COUNT_OUT_W = 11;

	// one input element
	typedef struct packed {
		logic signed [VALUE_W-1:0] element_value;
		logic                      last_item;
	} elem_t;

	// one result per array
	typedef struct packed {
		logic                      found;
		logic signed [VALUE_W-1:0] majority_value;
		logic                      overflow;
		logic [COUNT_OUT_W-1:0]    item_count;
	} res_t;

endpackage
`default_nettype wire

FILE: design/mef_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mef_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module mef_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2048,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

FILE: design/mef_job_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mef_job_fifo
// Two-entry queue of finished arrays between the load and verify sides.
// ----------------------------------------------------------------------------
module mef_job_fifo #(
	parameter int WIDTH = 45
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] push_data,
	input  wire logic             pop,
	output logic      [WIDTH-1:0] pop_data,
	output logic                  not_empty
);

	logic [WIDTH-1:0] entry_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       fill_q;

	assign pop_data  = entry_q[rd_ptr_q];
	assign not_empty = (fill_q != 2'd0);

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

endmodule
`default_nettype wire

FILE: design/mef_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mef_front
// Load side: stores up to MAX_ITEMS elements per array into the current bank
// and tracks the pairwise-cancellation candidate; on the last element it queues a job.
// ----------------------------------------------------------------------------
module mef_front import mef_pkg::*; #(
	parameter int MAX_ITEMS = 1024,
	localparam int IW    = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1,
	localparam int CW    = $clog2(MAX_ITEMS + 1),
	localparam int JOB_W = 2 + CW + VALUE_W
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               elem_valid,
	output logic                    elem_stall,
	input  wire elem_t              elem,
	output logic                    wr_en,
	output logic      [IW:0]        wr_addr,
	output logic      [VALUE_W-1:0] wr_data,
	output logic                    job_push,
	output logic      [JOB_W-1:0]   job,
	input  wire logic               job_done
);

	typedef struct packed {
		logic               bank;
		logic               ovf;
		logic [CW-1:0]      count;
		logic [VALUE_W-1:0] cand;
	} job_t;

	localparam logic [1:0] MAX_JOBS = 2'd2;

	logic               bank_q;
	logic [CW-1:0]      count_q;
	logic [CW-1:0]      votes_q;
	logic [VALUE_W-1:0] cand_q;
	logic               ovf_q;
	logic [1:0]         jobs_q;

	logic               acc;
	logic               full;
	logic [CW-1:0]      count_n;
	logic [CW-1:0]      votes_n;
	logic [VALUE_W-1:0] cand_n;
	logic               ovf_n;
	job_t               job_s;

	// both banks busy until the oldest job is verified
	assign elem_stall = (jobs_q == MAX_JOBS);
	assign acc        = elem_valid && !elem_stall;
	assign full       = (count_q == CW'(MAX_ITEMS));

	// store write
	assign wr_en   = acc && !full;
	assign wr_addr = {bank_q, count_q[IW-1:0]};
	assign wr_data = elem.element_value;

	// candidate vote and counters after this element
	always_comb begin
		count_n = count_q;
		votes_n = votes_q;
		cand_n  = cand_q;
		ovf_n   = ovf_q;
		if (full) begin
			ovf_n = 1'b1;
		end else begin
			count_n = count_q + 1'b1;
			if (votes_q == '0) begin
				cand_n  = elem.element_value;
				votes_n = CW'(1);
			end else if (elem.element_value == cand_q) begin
				votes_n = votes_q + 1'b1;
			end else begin
				votes_n = votes_q - 1'b1;
			end
		end
	end

	// job handed to the verify side
	assign job_push    = acc && elem.last_item;
	assign job_s.bank  = bank_q;
	assign job_s.ovf   = ovf_n;
	assign job_s.count = count_n;
	assign job_s.cand  = cand_n;
	assign job         = job_s;

	// candidate payload
	always_ff @(posedge clk) begin
		if (acc) begin
			cand_q <= cand_n;
		end
	end

	// array control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_q  <= 1'b0;
			count_q <= '0;
			votes_q <= '0;
			ovf_q   <= 1'b0;
		end else if (acc) begin
			if (elem.last_item) begin
				bank_q  <= ~bank_q;
				count_q <= '0;
				votes_q <= '0;
				ovf_q   <= 1'b0;
			end else begin
				count_q <= count_n;
				votes_q <= votes_n;
				ovf_q   <= ovf_n;
			end
		end
	end

	// jobs queued or under verification
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			jobs_q <= 2'd0;
		end else if (job_push && !job_done) begin
			jobs_q <= jobs_q + 2'd1;
		end else if (job_done && !job_push) begin
			jobs_q <= jobs_q - 2'd1;
		end
	end

endmodule
`default_nettype wire

FILE: design/mef_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mef_back
// Verify side: counts how often the candidate occurs in its bank, one read
// a cycle, and loads the result register.
// ----------------------------------------------------------------------------
module mef_back import mef_pkg::*; #(
	parameter int MAX_ITEMS = 1024,
	localparam int IW    = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1,
	localparam int CW    = $clog2(MAX_ITEMS + 1),
	localparam int JOB_W = 2 + CW + VALUE_W
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               job_avail,
	output logic                    job_pop,
	input  wire logic [JOB_W-1:0]   job,
	output logic                    rd_en,
	output logic      [IW:0]        rd_addr,
	input  wire logic [VALUE_W-1:0] rd_data,
	output logic                    job_done,
	output logic                    res_valid,
	input  wire logic               res_stall,
	output res_t                    res
);

	typedef struct packed {
		logic               bank;
		logic               ovf;
		logic [CW-1:0]      count;
		logic [VALUE_W-1:0] cand;
	} job_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	state_t        state_q;
	job_t          job_in;
	job_t          job_q;
	logic [CW-1:0] idx_q;
	logic [CW-1:0] hits_q;
	logic          rd_s1;
	logic          slot_free;
	logic          emit;
	logic          found;

	assign job_in    = job;
	assign slot_free = !res_valid || !res_stall;

	// start, read and finish conditions
	assign job_pop  = (state_q == ST_IDLE) && job_avail;
	assign rd_en    = (state_q == ST_SCAN);
	assign rd_addr  = {job_q.bank, idx_q[IW-1:0]};
	assign emit     = (state_q == ST_DONE) && !rd_s1 && slot_free;
	assign job_done = emit;
	assign found    = !job_q.ovf && (job_q.count != '0) && (hits_q > (job_q.count >> 1));

	// job payload
	always_ff @(posedge clk) begin
		if (job_pop) begin
			job_q <= job_in;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
			rd_s1   <= 1'b0;
			hits_q  <= '0;
		end else begin
			rd_s1 <= rd_en;
			if (rd_s1 && (rd_data == job_q.cand)) begin
				hits_q <= hits_q + 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (job_avail) begin
						idx_q  <= '0;
						hits_q <= '0;
						if (job_in.ovf || (job_in.count == '0)) begin
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == CW'(job_q.count - 1'b1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (emit) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (emit) begin
			res.found          <= found;
			res.majority_value <= found ? job_q.cand : '0;
			res.overflow       <= job_q.ovf;
			res.item_count     <= COUNT_OUT_W'(job_q.count);
		end
	end

	// result valid, cleared on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (emit) begin
			res_valid <= 1'b1;
		end else if (!res_stall) begin
			res_valid <= 1'b0;
		end
	end

endmodule
`default_nettype wire

FILE: design/majority_element_finder_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// majority_element_finder_core
// Finds the value that occurs in more than half of an array of elements.
//
//   channel  direction  handshake                payload
//   elem     in         elem_valid / elem_stall  elem_t: element_value, last_item
//   res      out        res_valid / res_stall    res_t: found, majority_value,
//                                                overflow, item_count
//
// Loading accepts an element whenever elem_stall is low; the store has two
// banks, so the next array loads while the previous one is verified.
// Verifying an array of n elements reads all n from the store through its
// single read port, unless the array overflowed; n is at most MAX_ITEMS.
// elem_stall rises once two arrays wait for or are in verification.
// A waiting result holds in the output register while loading continues.
// Reset clears all control state; the store needs no clearing.
// ----------------------------------------------------------------------------
module majority_element_finder_core import mef_pkg::*; #(
	parameter int MAX_ITEMS = 1024
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  elem_valid,
	output logic       elem_stall,
	input  wire elem_t elem,
	output logic       res_valid,
	input  wire logic  res_stall,
	output res_t       res
);

	localparam int IW    = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
	localparam int CW    = $clog2(MAX_ITEMS + 1);
	localparam int JOB_W = 2 + CW + VALUE_W;

	logic               wr_en;
	logic [IW:0]        wr_addr;
	logic [VALUE_W-1:0] wr_data;
	logic               rd_en;
	logic [IW:0]        rd_addr;
	logic [VALUE_W-1:0] rd_data;
	logic               job_push;
	logic [JOB_W-1:0]   job_in;
	logic               job_pop;
	logic [JOB_W-1:0]   job_out;
	logic               job_avail;
	logic               job_done;

	// load side
	mef_front #(
		.MAX_ITEMS(MAX_ITEMS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.elem_valid(elem_valid),
		.elem_stall(elem_stall),
		.elem      (elem),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.job_push  (job_push),
		.job       (job_in),
		.job_done  (job_done)
	);

	// two-bank value store
	mef_ram #(
		.WIDTH(VALUE_W),
		.DEPTH(2 * (1 << IW))
	) u_store (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// job queue between the sides
	mef_job_fifo #(
		.WIDTH(JOB_W)
	) u_jobs (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (job_push),
		.push_data(job_in),
		.pop      (job_pop),
		.pop_data (job_out),
		.not_empty(job_avail)
	);

	// verify side
	mef_back #(
		.MAX_ITEMS(MAX_ITEMS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.job_avail(job_avail),
		.job_pop  (job_pop),
		.job      (job_out),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data),
		.job_done (job_done),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res      (res)
	);

endmodule
`default_nettype wire
